// ===== hdl/four_wheel_speed_pi_mixer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the four-wheel speed PI mixer
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef FOUR_WHEEL_SPEED_PI_MIXER_ASSERT_SVH
`define FOUR_WHEEL_SPEED_PI_MIXER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FWPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwpm: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define FWPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwpm: next-cycle check failed");

`endif

// ===== hdl/fwpm_pkg.sv =====
// ---------------------------------------------------------------------------
// fwpm_pkg
// Types, widths and register codes of the four-wheel speed PI mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package fwpm_pkg;

  // Field and datapath widths
  localparam int IO_W    = 16;  // Q12.4 rpm in, Q5.10 V out
  localparam int ERR_W   = 20;  // Q14.6 rpm error
  localparam int GAIN_W  = 24;  // Q0.24 gain
  localparam int LIM_W   = 15;  // Q5.10 V limit register
  localparam int ACC_W   = 40;  // Q9.30 V accumulator
  localparam int PROD_W  = 46;  // gain times error delta
  localparam int SUM_W   = 48;  // accumulator plus both products
  localparam int MIX_W   = 42;  // three accumulators added
  localparam int LIM_SH  = 20;  // Q.10 to Q.30
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // Axle balance limit, 2.4 V in Q.30
  localparam logic [ACC_W-1:0] AXLE_LIMIT_Q30 = 40'd2576980378;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PROP_SPEED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_SPEED = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROP_AXLE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_AXLE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PROP_STEER  = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEG_STEER = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPEED_LIM   = 3'd6;
  localparam logic [IDX_W-1:0] REG_STEER_LIM   = 3'd7;

  // Input beat
  typedef struct packed {
    logic signed [IO_W-1:0] speed_right_rear;
    logic signed [IO_W-1:0] speed_left_rear;
    logic signed [IO_W-1:0] speed_right_front;
    logic signed [IO_W-1:0] speed_left_front;
    logic signed [IO_W-1:0] steering_demand;
    logic signed [IO_W-1:0] speed_target;
  } fwpm_in_t;

  // Result beat
  typedef struct packed {
    logic signed [IO_W-1:0] drive_right_rear;
    logic signed [IO_W-1:0] drive_left_rear;
    logic signed [IO_W-1:0] drive_right_front;
    logic signed [IO_W-1:0] drive_left_front;
  } fwpm_out_t;

  // Stage load strobes handed to each loop
  typedef struct packed {
    logic cap_en;  // error captured, previous error advanced
    logic mul_en;  // products registered
    logic acc_en;  // accumulator updated
  } fwpm_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/fwpm_pi_loop.sv =====
// ---------------------------------------------------------------------------
// fwpm_pi_loop
// One incremental PI loop: error delta, gain products, saturating accumulator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_wheel_speed_pi_mixer_assert.svh"

module fwpm_pi_loop (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire fwpm_pkg::fwpm_ctl_t                 ctl,
  input  wire logic signed [fwpm_pkg::ERR_W-1:0]   err,
  input  wire logic        [fwpm_pkg::GAIN_W-1:0]  kp,
  input  wire logic        [fwpm_pkg::GAIN_W-1:0]  ki,
  input  wire logic        [fwpm_pkg::ACC_W-1:0]   lim,
  output logic signed      [fwpm_pkg::ACC_W-1:0]   acc
);
  import fwpm_pkg::*;

  logic signed [ERR_W-1:0]  eprev_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W:0]    dlt_r;
  logic signed [ERR_W:0]    dlt_nxt;
  logic signed [PROD_W-1:0] prop_r;
  logic signed [PROD_W-1:0] prop_nxt;
  logic signed [PROD_W-1:0] integ_r;
  logic signed [PROD_W-1:0] integ_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_pos;
  logic signed [SUM_W-1:0]  lim_neg;

  // Error change against the previous item of this loop
  assign dlt_nxt = {err[ERR_W-1], err} - {eprev_r[ERR_W-1], eprev_r};

  // Capture error and advance the previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eprev_r <= '0;
    end else if (ctl.cap_en) begin
      eprev_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      err_r <= err;
      dlt_r <= dlt_nxt;
    end
  end

  // Gain products, gains taken as non-negative
  assign prop_nxt  = $signed({1'b0, kp}) * dlt_r;
  assign integ_nxt = $signed({1'b0, ki}) * err_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prop_r  <= prop_nxt;
      integ_r <= integ_nxt;
    end
  end

  // Accumulate and clamp to plus or minus the limit
  assign sum     = SUM_W'(acc_r) + SUM_W'(prop_r) + SUM_W'(integ_r);
  assign lim_pos = $signed(SUM_W'(lim));
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (sum > lim_pos) begin
      acc_nxt = ACC_W'(lim_pos);
    end else if (sum < lim_neg) begin
      acc_nxt = ACC_W'(lim_neg);
    end else begin
      acc_nxt = ACC_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

  // Accumulator moves only on its own load strobe
  `FWPM_ASSERT_NEXT(a_acc_hold, !ctl.acc_en, $stable(acc_r))
  // Previous error follows the captured error
  `FWPM_ASSERT_NEXT(a_eprev_track, ctl.cap_en, eprev_r == err_r)
  // Previous error holds between captures
  `FWPM_ASSERT_NEXT(a_eprev_hold, !ctl.cap_en, $stable(eprev_r))

endmodule

`default_nettype wire

// ===== hdl/four_wheel_speed_pi_mixer.sv =====
// ---------------------------------------------------------------------------
// four_wheel_speed_pi_mixer
// Four incremental PI loops (speed, axle balance, rear and front steering)
// mixed into four saturated Q5.10 motor drive voltages.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one sample of four wheel
//   speeds, steering demand and speed target. Result channel
//   out_valid/out_ready/out_data carries the four drive voltages, one result
//   beat per input beat, in order.
//   Stages: error capture, gain products, accumulator update, then mix and
//   round into the result register.
//   Throughput: one beat per cycle unless out_ready stalls; accumulator feedback
//   is a single register, so every stage can take a new beat each cycle.
//   Stall: when out_ready is low a valid result register holds, then the stages
//   behind it fill one by one; in_ready drops only once all of them are full.
//   Reset: rst_n (synchronous) empties the pipeline, clears accumulators and
//   previous errors, and loads the default gains and limits.
//   Config: APB registers at 4*index, to be written only while no beat is in flight (user's duty, not enforced).
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_wheel_speed_pi_mixer_assert.svh"

module four_wheel_speed_pi_mixer (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // input channel
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire fwpm_pkg::fwpm_in_t                 in_data,
  // result channel
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output fwpm_pkg::fwpm_out_t                     out_data,
  // configuration port
  input  wire                                     psel,
  input  wire                                     penable,
  input  wire                                     pwrite,
  input  wire logic [fwpm_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [fwpm_pkg::DATA_W-1:0]        pwdata,
  output logic      [fwpm_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import fwpm_pkg::*;

  localparam int WIDE_W = ERR_W + 1;

  // Configuration registers
  logic [GAIN_W-1:0] kp_spd_r, ki_spd_r, kp_axl_r, ki_axl_r, kp_str_r, ki_str_r;
  logic [LIM_W-1:0]  lim_spd_r, lim_str_r;
  logic [IDX_W-1:0]  cfg_idx;
  logic              cfg_wr;

  // Pipeline control
  logic      v1_r, v2_r, v3_r, out_valid_r;
  logic      ld1, ld2, ld3, ld_out;
  fwpm_ctl_t ctl;

  // Errors
  logic signed [WIDE_W-1:0] rr, lr, rf, lf, st, tg;
  logic signed [WIDE_W-1:0] e_spd_w, e_axl_w, e_rear_w, e_front_w;
  logic signed [ERR_W-1:0]  e_spd, e_axl, e_rear, e_front;

  // Loop outputs and mix
  logic signed [ACC_W-1:0] acc_spd, acc_axl, acc_rear, acc_front;
  logic [ACC_W-1:0]        lim_spd_q30, lim_str_q30;
  logic signed [MIX_W-1:0] mix_rr, mix_lr, mix_rf, mix_lf;
  fwpm_out_t               out_data_r;

  // Round to nearest (ties up) from Q.30 to Q.10 and saturate to 16 bits
  function automatic logic signed [IO_W-1:0] to_drive(input logic signed [MIX_W-1:0] s);
    logic signed [MIX_W:0]        x;
    logic signed [MIX_W-LIM_SH:0] r;
    logic signed [MIX_W-LIM_SH:0] hi;
    logic signed [MIX_W-LIM_SH:0] lo;
    x  = (MIX_W+1)'(s) + (MIX_W+1)'(1 <<< (LIM_SH - 1));
    r  = (MIX_W-LIM_SH+1)'(x >>> LIM_SH);
    hi = (MIX_W-LIM_SH+1)'(2**(IO_W-1) - 1);
    lo = -hi - (MIX_W-LIM_SH+1)'(1);
    priority if (r > hi) begin
      return IO_W'(hi);
    end else if (r < lo) begin
      return IO_W'(lo);
    end else begin
      return IO_W'(r);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  assign cfg_idx = paddr[IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Load defaults on reset; otherwise write the addressed register, masked to its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_spd_r  <= 24'd218104;
      ki_spd_r  <= 24'd44795;
      kp_axl_r  <= 24'd83886;
      ki_axl_r  <= 24'd31709;
      kp_str_r  <= 24'd167772;
      ki_str_r  <= 24'd41943;
      lim_spd_r <= 15'd12288;
      lim_str_r <= 15'd6144;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROP_SPEED:  kp_spd_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_SPEED: ki_spd_r  <= pwdata[GAIN_W-1:0];
        REG_PROP_AXLE:   kp_axl_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_AXLE:  ki_axl_r  <= pwdata[GAIN_W-1:0];
        REG_PROP_STEER:  kp_str_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_STEER: ki_str_r  <= pwdata[GAIN_W-1:0];
        REG_SPEED_LIM:   lim_spd_r <= pwdata[LIM_W-1:0];
        REG_STEER_LIM:   lim_str_r <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_PROP_SPEED:  prdata = DATA_W'(kp_spd_r);
      REG_INTEG_SPEED: prdata = DATA_W'(ki_spd_r);
      REG_PROP_AXLE:   prdata = DATA_W'(kp_axl_r);
      REG_INTEG_AXLE:  prdata = DATA_W'(ki_axl_r);
      REG_PROP_STEER:  prdata = DATA_W'(kp_str_r);
      REG_INTEG_STEER: prdata = DATA_W'(ki_str_r);
      REG_SPEED_LIM:   prdata = DATA_W'(lim_spd_r);
      REG_STEER_LIM:   prdata = DATA_W'(lim_str_r);
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or drains
  // -------------------------------------------------------------------------
  assign ld_out   = v3_r && (!out_valid_r || out_ready);
  assign ld3      = v2_r && (!v3_r || ld_out);
  assign ld2      = v1_r && (!v2_r || ld3);
  assign in_ready = !v1_r || ld2;
  assign ld1      = in_valid && in_ready;

  assign ctl.cap_en = ld1;
  assign ctl.mul_en = ld2;
  assign ctl.acc_en = ld3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ld3) begin
        v2_r <= 1'b0;
      end
      if (ld3) begin
        v3_r <= 1'b1;
      end else if (ld_out) begin
        v3_r <= 1'b0;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Loop errors in Q14.6 rpm
  // -------------------------------------------------------------------------
  assign rr = WIDE_W'(in_data.speed_right_rear);
  assign lr = WIDE_W'(in_data.speed_left_rear);
  assign rf = WIDE_W'(in_data.speed_right_front);
  assign lf = WIDE_W'(in_data.speed_left_front);
  assign st = WIDE_W'(in_data.steering_demand);
  assign tg = WIDE_W'(in_data.speed_target);

  assign e_spd_w   = (tg <<< 2) - (rr + lr + rf + lf);
  assign e_axl_w   = ((rf + lf) - (rr + lr)) <<< 1;
  assign e_rear_w  = ((rr - lr) - (st <<< 1)) <<< 2;
  assign e_front_w = ((rf - lf) - (st <<< 1)) <<< 2;

  assign e_spd   = ERR_W'(e_spd_w);
  assign e_axl   = ERR_W'(e_axl_w);
  assign e_rear  = ERR_W'(e_rear_w);
  assign e_front = ERR_W'(e_front_w);

  // Limits in Q.30
  assign lim_spd_q30 = ACC_W'({lim_spd_r, {LIM_SH{1'b0}}});
  assign lim_str_q30 = ACC_W'({lim_str_r, {LIM_SH{1'b0}}});

  // -------------------------------------------------------------------------
  // PI loops
  // -------------------------------------------------------------------------
  fwpm_pi_loop u_loop_speed (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .err (e_spd),
    .kp (kp_spd_r), .ki (ki_spd_r), .lim (lim_spd_q30), .acc (acc_spd)
  );

  fwpm_pi_loop u_loop_axle (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .err (e_axl),
    .kp (kp_axl_r), .ki (ki_axl_r), .lim (AXLE_LIMIT_Q30), .acc (acc_axl)
  );

  fwpm_pi_loop u_loop_rear (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .err (e_rear),
    .kp (kp_str_r), .ki (ki_str_r), .lim (lim_str_q30), .acc (acc_rear)
  );

  fwpm_pi_loop u_loop_front (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .err (e_front),
    .kp (kp_str_r), .ki (ki_str_r), .lim (lim_str_q30), .acc (acc_front)
  );

  // -------------------------------------------------------------------------
  // Mix, round and saturate into the result register
  // -------------------------------------------------------------------------
  assign mix_rr = MIX_W'(acc_spd) + MIX_W'(acc_axl) - MIX_W'(acc_rear);
  assign mix_lr = MIX_W'(acc_spd) + MIX_W'(acc_axl) + MIX_W'(acc_rear);
  assign mix_rf = MIX_W'(acc_spd) - MIX_W'(acc_axl) - MIX_W'(acc_front);
  assign mix_lf = MIX_W'(acc_spd) - MIX_W'(acc_axl) + MIX_W'(acc_front);

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data_r.drive_right_rear  <= to_drive(mix_rr);
      out_data_r.drive_left_rear   <= to_drive(mix_lr);
      out_data_r.drive_right_front <= to_drive(mix_rf);
      out_data_r.drive_left_front  <= to_drive(mix_lf);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Accepted beat lands in the capture stage
  `FWPM_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v1_r)
  // A stalled result blocks the accumulator stage from draining
  `FWPM_ASSERT_NOW(a_out_blocks, out_valid_r && !out_ready, !ld_out)
  // A full accumulator stage that cannot drain keeps its beat
  `FWPM_ASSERT_NEXT(a_s3_keeps, v3_r && !ld_out, v3_r)

endmodule

`default_nettype wire
